// File: rtl/sha256_hash_engine_top_macros.svh
// ----------------------------------------------------------------------------
// SHA-256 hash engine assertion macros
// Overlapping-implication and next-cycle checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef SHA256_HASH_ENGINE_TOP_MACROS_SVH
`define SHA256_HASH_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SHA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 engine package
// Shared types, round constants, initial hash values and sigma functions.
// ----------------------------------------------------------------------------
package sha_pkg;

	typedef logic [7:0][31:0] sha_words_t;

	typedef struct packed {
		logic init;
		logic load;
		logic step;
	} sha_ctl_t;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	localparam sha_words_t H_INIT = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [31:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

// File: rtl/sha_sched.sv
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// Sixteen-word window: filled with message words, then extended per round.
// ----------------------------------------------------------------------------
module sha_sched (
	input  logic              clk,
	input  sha_pkg::sha_ctl_t ctl,
	input  logic [31:0]       load_word,
	output logic [31:0]       w
);
	import sha_pkg::*;

	logic [31:0] win_q [16];
	logic [31:0] next_word;

	assign w = win_q[0];
	assign next_word = small_sig1(win_q[14]) + win_q[9] + small_sig0(win_q[1]) + win_q[0];

	always_ff @(posedge clk) begin
		if (ctl.load || ctl.step) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= ctl.load ? load_word : next_word;
		end
	end

endmodule

// File: rtl/sha_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Working variables a..h and one compression round per step.
// ----------------------------------------------------------------------------
module sha_round (
	input  logic               clk,
	input  sha_pkg::sha_ctl_t  ctl,
	input  sha_pkg::sha_words_t h_in,
	input  logic [5:0]         rnd,
	input  logic [31:0]        w,
	output sha_pkg::sha_words_t v
);
	import sha_pkg::*;

	sha_words_t v_q;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] mj;

	assign v  = v_q;
	assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1 = v_q[7] + big_sig1(v_q[4]) + ch + ROUND_K[rnd] + w;
	assign t2 = big_sig0(v_q[0]) + mj;

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			v_q <= h_in;
		end else if (ctl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

// File: rtl/sha256_hash_engine_top.sv
// ----------------------------------------------------------------------------
// SHA-256 hash engine, top level
// Streaming byte absorb, padding sequencer, round unit and digest output.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): req_type 0 absorbs data_byte, 1 finishes
// the message. A transfer happens when in_valid is high and in_stall low.
// An absorb is taken while idle; the byte that completes a 64-byte block
// starts 64 rounds on the shared round unit and one feed-forward add.
// in_stall stays high while busy.
// An accepted finish moves to padding, which injects bytes one per cycle
// (0x80, zeros, the 64-bit big-endian bit count) through the absorb path,
// pausing while a block compresses, and so compresses one or two final
// blocks: 9 to 72 padding bytes in all.
// The output channel (out_valid/out_stall) then presents digest words H0..H7
// with word_index and last_word on the eighth; each word holds while
// out_stall is high. After the last transfer the engine reinitializes and
// accepts the next message. No byte is taken while a block compresses.
// Reset (arst_n low) loads the initial hash values and clears the counts.
// ----------------------------------------------------------------------------
`include "sha256_hash_engine_top_macros.svh"

module sha256_hash_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PAD  = 5'b00010,
		ST_COMP = 5'b00100,
		ST_ADD  = 5'b01000,
		ST_OUT  = 5'b10000
	} sha_state_t;

	sha_state_t  state_q;
	sha_words_t  h_q;
	sha_words_t  v;
	sha_ctl_t    ctl;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic [63:0] bits_q;
	logic [63:0] len_q;
	logic [23:0] word_q;
	logic        fin_q;
	logic        first_q;
	logic        two_q;
	logic        last_q;
	logic        in_xfer;
	logic        push;
	logic [7:0]  push_byte;
	logic [7:0]  pad_byte;
	logic [31:0] w;

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign digest_word = h_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = &idx_q;

	assign in_xfer = in_valid && !in_stall;
	assign push    = (in_xfer && !req_type) || (state_q == ST_PAD);

	always_comb begin
		if (first_q) begin
			pad_byte = PAD_MARK;
		end else if (!two_q && fill_q >= LEN_POS) begin
			pad_byte = len_q[{~fill_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign push_byte = (state_q == ST_PAD) ? pad_byte : data_byte;

	assign ctl.load = push && (&fill_q[1:0]);
	assign ctl.init = push && (&fill_q);
	assign ctl.step = (state_q == ST_COMP);

	sha_sched u_sched (
		.clk       (clk),
		.ctl       (ctl),
		.load_word ({word_q, push_byte}),
		.w         (w)
	);

	sha_round u_round (
		.clk  (clk),
		.ctl  (ctl),
		.h_in (h_q),
		.rnd  (rnd_q),
		.w    (w),
		.v    (v)
	);

	always_ff @(posedge clk) begin
		if (push) begin
			word_q <= {word_q[15:0], push_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			h_q     <= H_INIT;
			fill_q  <= '0;
			rnd_q   <= '0;
			idx_q   <= '0;
			bits_q  <= '0;
			len_q   <= '0;
			fin_q   <= 1'b0;
			first_q <= 1'b0;
			two_q   <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			if (push) begin
				fill_q <= fill_q + 6'd1;
				if (&fill_q) begin
					rnd_q   <= '0;
					last_q  <= fin_q && !two_q;
					state_q <= ST_COMP;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (req_type) begin
							fin_q   <= 1'b1;
							first_q <= 1'b1;
							len_q   <= bits_q;
							two_q   <= (fill_q >= LEN_POS);
							state_q <= ST_PAD;
						end else begin
							bits_q <= bits_q + 64'd8;
						end
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 6'd1;
					if (&rnd_q) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v[i];
					end
					if (last_q) begin
						idx_q   <= '0;
						state_q <= ST_OUT;
					end else if (fin_q) begin
						two_q   <= 1'b0;
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						idx_q <= idx_q + 3'd1;
						if (&idx_q) begin
							h_q     <= H_INIT;
							fill_q  <= '0;
							bits_q  <= '0;
							fin_q   <= 1'b0;
							last_q  <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SHA_ASSERT_IMP(a_out_blocks_in, out_valid, in_stall, "input open during digest output")
	`SHA_ASSERT_IMP(a_pad_in_finish, state_q == ST_PAD, fin_q, "padding without finish request")
	`SHA_ASSERT_NXT(a_round_end, (state_q == ST_COMP) && (&rnd_q), state_q == ST_ADD,
		"round 63 not followed by feed-forward add")
	`SHA_ASSERT_NXT(a_last_idle, out_valid && !out_stall && last_word, !out_valid && !in_stall,
		"engine not idle after last digest transfer")

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// SHA-256 hash engine testbench
// Streams byte messages of varied lengths into the engine, finishes each one,
// and compares every digest word with a SHA-256 model kept in the bench.
// Both channels idle and stall at random, with stretches of full speed.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic REQ_ABSORB = 1'b0;
	localparam logic REQ_FINISH = 1'b1;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] KTAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic       kind;
		logic [7:0] octet;
	} sha_req_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        req_type = REQ_ABSORB;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha_req_t     request_q [$];
	digest_item_t digest_q [$];

	logic [31:0] hash_st [8];
	logic [7:0]  blk [64];
	int unsigned blk_fill;
	logic [63:0] msg_bits;

	logic        in_fire = 1'b0;
	logic        out_fire = 1'b0;
	logic        in_calm = 1'b0;
	logic        out_calm = 1'b0;
	int unsigned in_wait = 0;
	int unsigned out_hold = 3;
	int          req_total = 0;
	int          req_done = 0;
	int          mismatches = 0;

	sha256_hash_engine_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
		logic [63:0] dbl;
		dbl = {x, x} >> n;
		return dbl[31:0];
	endfunction

	function automatic void clear_hash_state();
		for (int k = 0; k < 8; k++)
			hash_st[k] = IV[k];
		blk_fill = 0;
		msg_bits = '0;
	endfunction

	function automatic void fold_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2, ch, mj;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4 * t], blk[4 * t + 1], blk[4 * t + 2], blk[4 * t + 3]};
		for (int t = 16; t < 64; t++) begin
			s0 = ror32(w[t - 15], 7) ^ ror32(w[t - 15], 18) ^ (w[t - 15] >> 3);
			s1 = ror32(w[t - 2], 17) ^ ror32(w[t - 2], 19) ^ (w[t - 2] >> 10);
			w[t] = s1 + w[t - 7] + s0 + w[t - 16];
		end
		for (int k = 0; k < 8; k++)
			v[k] = hash_st[k];
		for (int t = 0; t < 64; t++) begin
			s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
			ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
			t1 = v[7] + s1 + ch + KTAB[t] + w[t];
			s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
			mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t2 = s0 + mj;
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int k = 0; k < 8; k++)
			hash_st[k] = hash_st[k] + v[k];
	endfunction

	function automatic void absorb_octet(input logic [7:0] octet);
		blk[blk_fill] = octet;
		blk_fill++;
		msg_bits = msg_bits + 64'd8;
		if (blk_fill == 64) begin
			fold_block();
			blk_fill = 0;
		end
	endfunction

	function automatic void finish_message();
		int unsigned pos;
		digest_item_t item;
		pos = blk_fill;
		blk[pos] = PAD_BYTE;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				blk[pos] = 8'h00;
				pos++;
			end
			fold_block();
			pos = 0;
		end
		while (pos < 56) begin
			blk[pos] = 8'h00;
			pos++;
		end
		for (int k = 0; k < 8; k++)
			blk[56 + k] = msg_bits[63 - 8 * k -: 8];
		fold_block();
		for (int k = 0; k < 8; k++) begin
			item.word = hash_st[k];
			item.index = k[2:0];
			item.last = (k == 7);
			digest_q.push_back(item);
		end
		clear_hash_state();
	endfunction

	task automatic log_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	task automatic push_req(input logic kind, input logic [7:0] octet);
		sha_req_t r;
		r.kind = kind;
		r.octet = octet;
		request_q.push_back(r);
	endtask

	task automatic push_message(input int unsigned len);
		for (int unsigned k = 0; k < len; k++)
			push_req(REQ_ABSORB, 8'($urandom_range(0, 255)));
		push_req(REQ_FINISH, 8'($urandom_range(0, 255)));
	endtask

	always @(posedge clk) begin
		digest_item_t exp_item;
		if (arst_n) begin
			in_fire <= in_valid && !in_stall;
			out_fire <= out_valid && !out_stall;
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					log_mismatch($sformatf("digest word %08h with nothing expected",
						digest_word));
				end else begin
					exp_item = digest_q.pop_front();
					if (digest_word !== exp_item.word)
						log_mismatch($sformatf("digest_word %08h, expected %08h",
							digest_word, exp_item.word));
					if (word_index !== exp_item.index)
						log_mismatch($sformatf("word_index %0d, expected %0d",
							word_index, exp_item.index));
					if (last_word !== exp_item.last)
						log_mismatch($sformatf("last_word %0b, expected %0b",
							last_word, exp_item.last));
				end
			end
			if (in_valid && !in_stall) begin
				req_done <= req_done + 1;
				if (req_type == REQ_FINISH)
					finish_message();
				else
					absorb_octet(data_byte);
			end
		end
	end

	always @(negedge clk) begin
		sha_req_t nxt;
		if (arst_n && !(in_valid && !in_fire)) begin
			if (in_wait != 0) begin
				in_valid <= 1'b0;
				in_wait <= in_wait - 1;
			end else if (request_q.size() != 0) begin
				nxt = request_q.pop_front();
				in_valid <= 1'b1;
				req_type <= nxt.kind;
				data_byte <= nxt.octet;
				in_wait <= in_calm ? 0 : $urandom_range(0, 7);
				if ($urandom_range(0, 39) == 0)
					in_calm <= !in_calm;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		int unsigned draw;
		if (arst_n) begin
			if (out_fire) begin
				draw = out_calm ? 0 : $urandom_range(0, 7);
				out_hold <= draw;
				out_stall <= (draw != 0);
				if ($urandom_range(0, 39) == 0)
					out_calm <= !out_calm;
			end else if (out_valid && out_hold != 0) begin
				out_hold <= out_hold - 1;
				out_stall <= (out_hold > 1);
			end
		end
	end

	initial begin
		int unsigned len;
		clear_hash_state();
		push_req(REQ_FINISH, 8'h00);
		push_req(REQ_ABSORB, 8'h61);
		push_req(REQ_ABSORB, 8'h62);
		push_req(REQ_ABSORB, 8'h63);
		push_req(REQ_FINISH, 8'hff);
		push_req(REQ_ABSORB, 8'hff);
		push_req(REQ_FINISH, 8'h00);
		push_req(REQ_ABSORB, 8'h00);
		push_req(REQ_FINISH, 8'hff);
		while (request_q.size() < 315) begin
			case ($urandom_range(0, 5))
				0: len = $urandom_range(0, 8);
				1: len = $urandom_range(55, 56);
				2: len = $urandom_range(63, 65);
				3: len = $urandom_range(119, 129);
				default: len = $urandom_range(0, 140);
			endcase
			push_message(len);
		end
		req_total = request_q.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (req_done < req_total || digest_q.size() != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
